// ----- rtl/core/ifhc_pkg.sv -----
// Types and constants for the IP forwarding header check.
`default_nettype none
package ifhc_pkg;

  localparam int PosWidth = 17;
  localparam int SumWidth = 21;

  localparam logic [PosWidth-1:0] POS_MAX = 17'h1ffff;

  localparam logic [3:0] VER_IPV4 = 4'd4;
  localparam logic [3:0] VER_IPV6 = 4'd6;

  // Byte offsets from the start of the layer-3 header
  localparam logic [PosWidth-1:0] V4_LEN_HI  = 17'd2;
  localparam logic [PosWidth-1:0] V4_LEN_LO  = 17'd3;
  localparam logic [PosWidth-1:0] V4_TTL     = 17'd8;
  localparam logic [PosWidth-1:0] V4_CSUM_HI = 17'd10;
  localparam logic [PosWidth-1:0] V4_CSUM_LO = 17'd11;
  localparam logic [PosWidth-1:0] V4_DST_HI  = 17'd16;
  localparam logic [PosWidth-1:0] V6_LEN_HI  = 17'd4;
  localparam logic [PosWidth-1:0] V6_LEN_LO  = 17'd5;
  localparam logic [PosWidth-1:0] V6_HOP     = 17'd7;

  localparam logic [PosWidth-1:0] V4_MIN_HDR = 17'd20;
  localparam logic [PosWidth-1:0] V6_HDR     = 17'd40;

  localparam logic [7:0] MCAST_LO = 8'he0;
  localparam logic [7:0] MCAST_HI = 8'hef;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
    logic [3:0] l3_version;
  } ifhc_in_t;

  typedef struct packed {
    logic        drop;
    logic [7:0]  new_hop_count;
    logic [15:0] new_checksum;
    logic        is_ipv4;
  } ifhc_out_t;

  // step: the held byte is consumed this cycle; load: it closes a packet
  typedef struct packed {
    logic step;
    logic load;
  } ifhc_ctl_t;

  function automatic logic [15:0] fold_sum(input logic [SumWidth:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s[15:0]} + {11'd0, s[SumWidth:16]};
    u = {1'b0, t[15:0]} + {16'd0, t[16]};
    return ~u[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ifhc_in_stage.sv -----
// Input register for packet bytes.
`default_nettype none
module ifhc_in_stage import ifhc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      pkt_valid,
  output logic           pkt_ready,
  input  wire ifhc_in_t  pkt,
  input  wire ifhc_ctl_t ctl,
  output logic           held_valid,
  output ifhc_in_t       held
);

  assign pkt_ready = !held_valid || ctl.step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (pkt_ready) begin
      held_valid <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_ready && pkt_valid) begin
      held <= pkt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ifhc_hdr_track.sv -----
// Per-packet header state, byte-wise updates and end-of-packet checks.
`default_nettype none
module ifhc_hdr_track import ifhc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     held_valid,
  input  wire ifhc_in_t held,
  input  wire logic     can_load,
  output ifhc_ctl_t     ctl,
  output ifhc_out_t     res_next
);

  logic [PosWidth-1:0] byte_position, byte_position_next;
  logic [SumWidth-1:0] running_sum, running_sum_next;
  logic [5:0]          header_bytes, header_bytes_next;
  logic [3:0]          version_nibble, version_nibble_next;
  logic [15:0]         length_field, length_field_next;
  logic [7:0]          hop_count, hop_count_next;
  logic                multicast_dest, multicast_dest_next;
  logic [3:0]          packet_version, packet_version_next;

  logic                first;
  logic                is_v4, is_v6;
  logic [7:0]          b;
  logic [SumWidth-1:0] addend;
  logic [PosWidth-1:0] len, hb_ext, lf_ext;
  logic                v4_bad, v6_bad;
  logic [7:0]          hop_out;
  logic                drop;

  assign ctl.step = held_valid && (!held.last_byte || can_load);
  assign ctl.load = ctl.step && held.last_byte;

  always_comb begin
    b     = held.pkt_byte;
    first = (byte_position == '0);

    packet_version_next = first ? held.l3_version : packet_version;
    version_nibble_next = first ? b[7:4] : version_nibble;
    header_bytes_next   = first ? {b[3:0], 2'b00} : header_bytes;
    is_v4 = (packet_version_next == VER_IPV4);
    is_v6 = (packet_version_next == VER_IPV6);

    length_field_next   = length_field;
    hop_count_next      = hop_count;
    multicast_dest_next = multicast_dest;
    addend              = '0;
    if (is_v4) begin
      if (byte_position == V4_LEN_HI) length_field_next = {b, length_field[7:0]};
      if (byte_position == V4_LEN_LO) length_field_next = {length_field[15:8], b};
      if (byte_position == V4_TTL) hop_count_next = b;
      if (byte_position == V4_DST_HI)
        multicast_dest_next = (b >= MCAST_LO) && (b <= MCAST_HI);
      // TTL and checksum bytes stay out of the sum; TTL is added at the end
      if (byte_position < {11'd0, header_bytes_next} && byte_position != V4_TTL &&
          byte_position != V4_CSUM_HI && byte_position != V4_CSUM_LO) begin
        addend = byte_position[0] ? {13'd0, b} : {5'd0, b, 8'd0};
      end
    end else if (is_v6) begin
      if (byte_position == V6_LEN_HI) length_field_next = {b, length_field[7:0]};
      if (byte_position == V6_LEN_LO) length_field_next = {length_field[15:8], b};
      if (byte_position == V6_HOP) hop_count_next = b;
    end
    running_sum_next   = running_sum + addend;
    byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                    : byte_position + PosWidth'(1);

    // end-of-packet checks on the updated values
    len    = byte_position_next;
    hb_ext = {11'd0, header_bytes_next};
    lf_ext = {1'b0, length_field_next};
    v4_bad = (len < V4_MIN_HDR) || (version_nibble_next != VER_IPV4) ||
             (hb_ext < V4_MIN_HDR) || (len < hb_ext) || (lf_ext < hb_ext) ||
             (lf_ext > len);
    v6_bad = (len < V6_HDR) || (version_nibble_next != VER_IPV6) ||
             (lf_ext > len - V6_HDR) || (hop_count_next <= 8'd1);

    hop_out = hop_count_next;
    drop    = 1'b1;
    if (is_v4) begin
      if (multicast_dest_next) begin
        drop = v4_bad;
      end else begin
        drop    = v4_bad || (hop_count_next <= 8'd1);
        hop_out = hop_count_next - 8'd1;
      end
    end else if (is_v6) begin
      drop    = v6_bad;
      hop_out = hop_count_next - 8'd1;
    end

    res_next.drop          = drop;
    res_next.new_hop_count = drop ? 8'd0 : hop_out;
    res_next.new_checksum  = (drop || !is_v4) ? 16'd0
                           : fold_sum({1'b0, running_sum_next} + {6'd0, hop_out, 8'd0});
    res_next.is_ipv4       = !drop && is_v4;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.load) begin
      byte_position  <= '0;
      running_sum    <= '0;
      header_bytes   <= '0;
      version_nibble <= '0;
      length_field   <= '0;
      hop_count      <= '0;
      multicast_dest <= 1'b0;
      packet_version <= '0;
    end else if (ctl.step) begin
      byte_position  <= byte_position_next;
      running_sum    <= running_sum_next;
      header_bytes   <= header_bytes_next;
      version_nibble <= version_nibble_next;
      length_field   <= length_field_next;
      hop_count      <= hop_count_next;
      multicast_dest <= multicast_dest_next;
      packet_version <= packet_version_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ifhc_out_stage.sv -----
// Result register toward the downstream consumer.
`default_nettype none
module ifhc_out_stage import ifhc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ifhc_ctl_t ctl,
  input  wire ifhc_out_t res_next,
  output logic           can_load,
  output logic           res_valid,
  input  wire logic      res_ready,
  output ifhc_out_t      res
);

  assign can_load = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (can_load) begin
      res_valid <= ctl.load;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ip_forward_header_check.sv -----
// IP forwarding header check: TTL/hop-limit decrement and IPv4 checksum update.
// Throughput: one packet byte per cycle, sustained across packet boundaries, while
// downstream takes results. A last byte goes via the input and result registers.
// A byte sits in the input register while its header update and checks are
// computed; the result register holds one finished result under backpressure.
// Reset (rst, synchronous) empties both registers and clears the header state.
`default_nettype none
module ip_forward_header_check import ifhc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     pkt_valid,
  output logic          pkt_ready,
  input  wire ifhc_in_t pkt,
  output logic          res_valid,
  input  wire logic     res_ready,
  output ifhc_out_t     res
);

  ifhc_ctl_t ctl;
  ifhc_in_t  held;
  ifhc_out_t res_next;
  logic      held_valid;
  logic      can_load;

  ifhc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .pkt_valid  (pkt_valid),
    .pkt_ready  (pkt_ready),
    .pkt        (pkt),
    .ctl        (ctl),
    .held_valid (held_valid),
    .held       (held)
  );

  ifhc_hdr_track u_track (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held       (held),
    .can_load   (can_load),
    .ctl        (ctl),
    .res_next   (res_next)
  );

  ifhc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .res_next  (res_next),
    .can_load  (can_load),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
`default_nettype wire
